@@ hw/rtl/tssc_pkg.sv @@
// types, table sizes and codes shared by the superframe slot check
// no dependencies; imported by tdma_superframe_slot_check and its testbench
package tssc_pkg;

  // table sizes
  localparam int DATA_SLOTS  = 16;
  localparam int HELLO_SLOTS = 16;

  localparam int DIDX_W   = (DATA_SLOTS > 1) ? $clog2(DATA_SLOTS) : 1;
  localparam int HIDX_W   = (HELLO_SLOTS > 1) ? $clog2(HELLO_SLOTS) : 1;
  localparam int SCAN_MAX = (DATA_SLOTS > HELLO_SLOTS) ? DATA_SLOTS : HELLO_SLOTS;
  localparam int SCAN_W   = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;

  // phase lengths used when the registers hold zero
  localparam logic [15:0] DEFAULT_DATA_LEN  = 16'd40;
  localparam logic [15:0] DEFAULT_HELLO_LEN = 16'd20;

  // item modes
  localparam logic [1:0] MODE_QUERY = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_HELLO = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_DATA_LEN    = 3'd0;
  localparam logic [2:0] REG_HELLO_LEN   = 3'd1;
  localparam logic [2:0] REG_HELLO_SLOT  = 3'd2;
  localparam logic [2:0] REG_DATA_COUNT  = 3'd3;
  localparam logic [2:0] REG_HELLO_COUNT = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] node_id;
    logic [31:0] unix_time;
    logic [3:0]  entry_index;
    logic [15:0] entry_start;
    logic [15:0] entry_duration;
    logic [7:0]  entry_slot;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_index;
    logic        in_data_window;
    logic        hello_phase;
    logic [15:0] pos_in_hello;
    logic        in_hello_slot;
    logic [7:0]  data_slot_id;
  } out_item_t;

endpackage

@@ hw/rtl/tdma_superframe_slot_check.sv @@
// superframe slot check: bit-serial divider, table scan and register port
// depends on tssc_pkg for item types, table sizes and codes
//
// Load items (mode 1 data entry, mode 2 hello entry) are written in the cycle
// they are accepted and give no result; mode 3 is dropped. A query is taken
// apart by a restoring divider that retires one quotient bit per cycle for
// the 32-bit time, then the phase and hello position are worked out, then
// both slot tables are walked one entry per cycle up to the larger table
// size, and the result is moved to the output register once the output is
// free. No new item is taken while a query is in flight. The next item is
// taken as soon as the result sits in the output register, even while that
// result is still stalled. The slot tables have no reset; write every entry
// below the configured counts before querying.
module tdma_superframe_slot_check (
  input  logic                 clk,
  input  logic                 rst,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tssc_pkg::in_item_t   in_item,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output tssc_pkg::out_item_t  out_item,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tssc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_PREP, S_SCAN, S_OUT} state_t;

  // configuration registers
  logic [15:0] data_len;
  logic [15:0] hello_len;
  logic [7:0]  hello_slot;
  logic [4:0]  data_count;
  logic [4:0]  hello_count;

  // slot tables
  logic [23:0] d_owner [DATA_SLOTS];
  logic [15:0] d_start [DATA_SLOTS];
  logic [15:0] d_len   [DATA_SLOTS];
  logic [7:0]  d_ident [DATA_SLOTS];
  logic [23:0] h_owner [HELLO_SLOTS];
  logic [7:0]  h_number[HELLO_SLOTS];

  // query datapath
  state_t      state;
  logic [4:0]  div_cnt;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [23:0] node;
  logic [15:0] pos_h;
  logic        hphase;
  logic        hello_ok;
  logic        data_ok;
  logic [SCAN_W-1:0] scan_cnt;
  logic        data_hit;
  logic        id_found;
  logic [7:0]  slot_id;
  logic        h_found;
  logic        hello_hit;

  logic        in_acc;
  logic        cfg_wr;
  logic [15:0] dlen_eff;
  logic [15:0] hlen_eff;
  logic [16:0] divisor;
  logic [17:0] trial;
  logic        trial_ge;
  logic [4:0]  dcount;
  logic [4:0]  hcount;
  logic        data_en;
  logic [12:0] used_raw;
  logic [15:0] used;
  logic        hphase_next;
  logic [15:0] pos_h_next;
  logic [DIDX_W-1:0] didx;
  logic [HIDX_W-1:0] hidx;
  logic        d_live;
  logic        h_live;
  logic        d_own;
  logic        h_own;
  logic [16:0] d_end;
  logic        d_in;
  logic [15:0] h_start;
  logic [16:0] h_end;
  logic        h_in;
  logic        out_free;

  // handshakes
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid || !out_stall;

  // effective lengths and counts
  assign dlen_eff = (data_len == 16'd0) ? DEFAULT_DATA_LEN : data_len;
  assign hlen_eff = (hello_len == 16'd0) ? DEFAULT_HELLO_LEN : hello_len;
  assign divisor  = {1'b0, dlen_eff} + {1'b0, hlen_eff};
  assign dcount   = (32'(data_count) > DATA_SLOTS) ? 5'(DATA_SLOTS) : data_count;
  assign hcount   = (32'(hello_count) > HELLO_SLOTS) ? 5'(HELLO_SLOTS) : hello_count;
  assign data_en  = (data_len != 16'd0) && (dcount != 5'd0);

  // one restoring division step
  assign trial    = {rem, quo[31]};
  assign trial_ge = (trial >= {1'b0, divisor});

  // phase and hello coverage from the remainder
  assign hphase_next = (rem >= {1'b0, dlen_eff});
  assign pos_h_next  = hphase_next ? 16'(rem - {1'b0, dlen_eff}) : 16'd0;
  assign used_raw    = 13'(hello_slot) * 13'(hcount);
  assign used        = ({3'd0, used_raw} > hlen_eff) ? hlen_eff : {3'd0, used_raw};

  // per-entry compares for the current scan position
  assign didx    = DIDX_W'(scan_cnt);
  assign hidx    = HIDX_W'(scan_cnt);
  assign d_live  = (32'(scan_cnt) < 32'(dcount));
  assign h_live  = (32'(scan_cnt) < 32'(hcount));
  assign d_own   = d_live && (d_owner[didx] == node);
  assign h_own   = h_live && (h_owner[hidx] == node);
  assign d_end   = {1'b0, d_start[didx]} + {1'b0, d_len[didx]};
  assign d_in    = (rem >= {1'b0, d_start[didx]}) && (rem < d_end);
  assign h_start = 16'(h_number[hidx]) * 16'(hello_slot);
  assign h_end   = {1'b0, h_start} + 17'(hello_slot);
  assign h_in    = (pos_h >= h_start) && ({1'b0, pos_h} < h_end);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      data_len    <= DEFAULT_DATA_LEN;
      hello_len   <= DEFAULT_HELLO_LEN;
      hello_slot  <= 8'd0;
      data_count  <= 5'd0;
      hello_count <= 5'd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_DATA_LEN:    data_len    <= pwdata[15:0];
        REG_HELLO_LEN:   hello_len   <= pwdata[15:0];
        REG_HELLO_SLOT:  hello_slot  <= pwdata[7:0];
        REG_DATA_COUNT:  data_count  <= pwdata[4:0];
        REG_HELLO_COUNT: hello_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:2])
      REG_DATA_LEN:    prdata = {16'd0, data_len};
      REG_HELLO_LEN:   prdata = {16'd0, hello_len};
      REG_HELLO_SLOT:  prdata = {24'd0, hello_slot};
      REG_DATA_COUNT:  prdata = {27'd0, data_count};
      REG_HELLO_COUNT: prdata = {27'd0, hello_count};
      default:         prdata = 32'd0;
    endcase
  end

  // table writes from load items
  always_ff @(posedge clk) begin
    if (in_acc && in_item.mode == MODE_DATA && 32'(in_item.entry_index) < DATA_SLOTS) begin
      d_owner[DIDX_W'(in_item.entry_index)] <= in_item.node_id;
      d_start[DIDX_W'(in_item.entry_index)] <= in_item.entry_start;
      d_len[DIDX_W'(in_item.entry_index)]   <= in_item.entry_duration;
      d_ident[DIDX_W'(in_item.entry_index)] <= in_item.entry_slot;
    end
    if (in_acc && in_item.mode == MODE_HELLO && 32'(in_item.entry_index) < HELLO_SLOTS) begin
      h_owner[HIDX_W'(in_item.entry_index)]  <= in_item.node_id;
      h_number[HIDX_W'(in_item.entry_index)] <= in_item.entry_slot;
    end
  end

  // query sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= 5'd0;
      scan_cnt  <= '0;
    end else begin
      // output valid: set on handoff, cleared once taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && in_item.mode == MODE_QUERY) begin
            quo     <= in_item.unix_time;
            rem     <= 17'd0;
            node    <= in_item.node_id;
            div_cnt <= 5'd31;
            state   <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          rem     <= trial_ge ? 17'(trial - {1'b0, divisor}) : trial[16:0];
          quo     <= {quo[30:0], trial_ge};
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          hphase    <= hphase_next;
          pos_h     <= pos_h_next;
          hello_ok  <= (hcount != 5'd0) && (hello_slot != 8'd0) && (pos_h_next < used);
          data_ok   <= data_en && (rem < {1'b0, data_len});
          scan_cnt  <= '0;
          data_hit  <= 1'b0;
          id_found  <= 1'b0;
          slot_id   <= 8'd0;
          h_found   <= 1'b0;
          hello_hit <= 1'b0;
          state     <= S_SCAN;
        end
        // one entry of each table per cycle
        S_SCAN: begin
          if (data_ok && d_own && d_in) begin
            data_hit <= 1'b1;
          end
          if (d_own && !id_found) begin
            id_found <= 1'b1;
            slot_id  <= d_ident[didx];
          end
          if (hello_ok && h_own && !h_found) begin
            h_found   <= 1'b1;
            hello_hit <= h_in;
          end
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_cnt == SCAN_W'(SCAN_MAX - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_item.frame_index     <= data_en ? quo : 32'd0;
            out_item.in_data_window  <= data_hit;
            out_item.hello_phase     <= hphase;
            out_item.pos_in_hello    <= pos_h;
            out_item.in_hello_slot   <= hello_hit;
            out_item.data_slot_id    <= slot_id;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // remainder is reduced once the division finishes
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |-> (rem < divisor))
    else $error("division remainder not below superframe length");

  // hello position stays inside the hello phase
  a_pos_h_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos_h < hlen_eff))
    else $error("hello position past hello phase");

  // an accepted query starts the divider
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.mode == MODE_QUERY) |=> (state == S_DIV && div_cnt == 5'd31))
    else $error("query did not start division");

  // a fresh result only appears when leaving the output state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT && state == S_IDLE))
    else $error("result raised outside output handoff");

  // load items never start a query
  a_load_no_query: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.mode != MODE_QUERY) |=> (state == S_IDLE))
    else $error("load item left idle");
`endif

endmodule

@@ tb/sv/tdma_superframe_slot_check_tb.sv @@
// testbench for tdma_superframe_slot_check: table loads, queries, register writes
// depends on tssc_pkg and the tdma_superframe_slot_check rtl; a scoreboard class
// predicts each query result from its own copy of the slot tables and registers

module tdma_superframe_slot_check_tb;
  import tssc_pkg::*;

  // keeps the schedule state, works out each query result and checks what comes out
  class slot_scoreboard;
    logic [15:0] data_len;
    logic [15:0] hello_len;
    logic [7:0]  hello_slot_len;
    logic [4:0]  data_count;
    logic [4:0]  hello_count;
    logic [23:0] data_owner [DATA_SLOTS];
    logic [15:0] data_start [DATA_SLOTS];
    logic [15:0] data_length [DATA_SLOTS];
    logic [7:0]  data_ident [DATA_SLOTS];
    logic [23:0] hello_owner [HELLO_SLOTS];
    logic [7:0]  hello_number [HELLO_SLOTS];
    out_item_t   awaited[$];
    int          errors;

    function new();
      data_len       = DEFAULT_DATA_LEN;
      hello_len      = DEFAULT_HELLO_LEN;
      hello_slot_len = '0;
      data_count     = '0;
      hello_count    = '0;
      errors         = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_DATA_LEN:    data_len = value[15:0];
        REG_HELLO_LEN:   hello_len = value[15:0];
        REG_HELLO_SLOT:  hello_slot_len = value[7:0];
        REG_DATA_COUNT:  data_count = value[4:0];
        REG_HELLO_COUNT: hello_count = value[4:0];
        default: ;
      endcase
    endfunction

    // frame, data window, hello phase and slot ownership for one query
    function out_item_t schedule_lookup(in_item_t q);
      out_item_t   r;
      int unsigned dcnt, hcnt, hlen, dlen, period, pos, ph, used, base, t;
      int          i;
      r    = '0;
      t    = q.unix_time;
      dcnt = (data_count > DATA_SLOTS) ? DATA_SLOTS : data_count;
      hcnt = (hello_count > HELLO_SLOTS) ? HELLO_SLOTS : hello_count;
      hlen = (hello_len == 0) ? DEFAULT_HELLO_LEN : hello_len;

      // data window, only with a real data length and some entries
      if (data_len != 0 && dcnt != 0) begin
        period = 32'(data_len) + hlen;
        r.frame_index = t / period;
        pos = t % period;
        if (pos < data_len) begin
          for (i = 0; i < dcnt; i++) begin
            if (data_owner[i] == q.node_id && pos >= data_start[i] &&
                pos < 32'(data_start[i]) + 32'(data_length[i])) begin
              r.in_data_window = 1'b1;
              break;
            end
          end
        end
      end

      // phase within the superframe, zero data length counts as default
      dlen   = (data_len == 0) ? DEFAULT_DATA_LEN : data_len;
      period = dlen + hlen;
      pos    = t % period;
      ph     = 0;
      r.hello_phase = (pos >= dlen);
      if (r.hello_phase) begin
        ph = pos - dlen;
        if (ph >= hlen) ph = hlen - 1;
      end
      r.pos_in_hello = ph[15:0];

      // hello slot of the first entry owned by the node
      if (hcnt != 0 && ph < hlen && hello_slot_len != 0) begin
        used = 32'(hello_slot_len) * hcnt;
        if (used > hlen) used = hlen;
        if (ph < used) begin
          for (i = 0; i < hcnt; i++) begin
            if (hello_owner[i] == q.node_id) begin
              base = 32'(hello_number[i]) * 32'(hello_slot_len);
              if (ph >= base && ph < base + hello_slot_len) r.in_hello_slot = 1'b1;
              break;
            end
          end
        end
      end

      // id of the first data entry owned by the node
      for (i = 0; i < dcnt; i++) begin
        if (data_owner[i] == q.node_id) begin
          r.data_slot_id = data_ident[i];
          break;
        end
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      case (it.mode)
        MODE_DATA: begin
          if (it.entry_index < DATA_SLOTS) begin
            data_owner[it.entry_index]  = it.node_id;
            data_start[it.entry_index]  = it.entry_start;
            data_length[it.entry_index] = it.entry_duration;
            data_ident[it.entry_index]  = it.entry_slot;
          end
        end
        MODE_HELLO: begin
          if (it.entry_index < HELLO_SLOTS) begin
            hello_owner[it.entry_index]  = it.node_id;
            hello_number[it.entry_index] = it.entry_slot;
          end
        end
        MODE_QUERY: awaited.push_back(schedule_lookup(it));
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("result arrived with nothing awaited");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.frame_index !== want.frame_index) begin
        $error("frame_index: expected %0d, got %0d", want.frame_index, got.frame_index);
        errors++;
      end
      if (got.in_data_window !== want.in_data_window) begin
        $error("in_data_window: expected %0d, got %0d", want.in_data_window,
               got.in_data_window);
        errors++;
      end
      if (got.hello_phase !== want.hello_phase) begin
        $error("hello_phase: expected %0d, got %0d", want.hello_phase, got.hello_phase);
        errors++;
      end
      if (got.pos_in_hello !== want.pos_in_hello) begin
        $error("pos_in_hello: expected %0d, got %0d", want.pos_in_hello, got.pos_in_hello);
        errors++;
      end
      if (got.in_hello_slot !== want.in_hello_slot) begin
        $error("in_hello_slot: expected %0d, got %0d", want.in_hello_slot,
               got.in_hello_slot);
        errors++;
      end
      if (got.data_slot_id !== want.data_slot_id) begin
        $error("data_slot_id: expected %0d, got %0d", want.data_slot_id, got.data_slot_id);
        errors++;
      end
    endfunction
  endclass

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int WAIT_LIMIT    = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  slot_scoreboard sb = new();

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic long_hold = 1'b0;
  int   held = 0;

  logic [23:0] node_pool [6] = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h000002,
                                 24'h800001, 24'h5A5A5A};

  tdma_superframe_slot_check uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #12000000;
    $display("*** FAILED ***");
    $finish;
  end

  // handshakes are sampled mid-cycle, where every signal has settled
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (in_valid && !in_stall) sb.note_item(in_item);
    end
  end

  // receiver: random stalls, plus one long hold counted here
  always @(posedge clk) begin
    if (long_hold && held < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      held      <= held + 1;
    end else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // offer one item, return at the edge that takes it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // stop sending and let every awaited result come out
  task automatic wait_results(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] dlen, input logic [15:0] hlen,
                                input logic [7:0] hsec, input logic [4:0] dcnt,
                                input logic [4:0] hcnt);
    wait_results(SETTLE_CYCLES);
    write_reg(REG_DATA_LEN, 32'(dlen));
    write_reg(REG_HELLO_LEN, 32'(hlen));
    write_reg(REG_HELLO_SLOT, 32'(hsec));
    write_reg(REG_DATA_COUNT, 32'(dcnt));
    write_reg(REG_HELLO_COUNT, 32'(hcnt));
  endtask

  // mostly well-formed loads and queries aimed at the current superframe
  function automatic in_item_t make_item();
    in_item_t    it;
    int unsigned dl, hl, period, sel;
    dl     = (sb.data_len == 0) ? DEFAULT_DATA_LEN : sb.data_len;
    hl     = (sb.hello_len == 0) ? DEFAULT_HELLO_LEN : sb.hello_len;
    period = dl + hl;
    it.mode           = MODE_QUERY;
    it.node_id        = ($urandom_range(99) < 80) ? node_pool[$urandom_range(0, 5)]
                                                  : 24'($urandom);
    it.unix_time      = $urandom;
    it.entry_index    = 4'($urandom);
    it.entry_start    = 16'($urandom);
    it.entry_duration = 16'($urandom);
    it.entry_slot     = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 55) begin
      if ($urandom_range(1))
        it.unix_time = $urandom_range(0, 32'hFFFFFFFF / period) * period +
                       $urandom_range(0, period - 1);
    end else if (sel < 75) begin
      it.mode = MODE_DATA;
      if ($urandom_range(99) < 70) begin
        it.entry_start    = 16'($urandom_range(0, dl - 1));
        it.entry_duration = 16'($urandom_range(1, dl / 3 + 1));
      end
    end else if (sel < 96) begin
      it.mode = MODE_HELLO;
      if ($urandom_range(99) < 70) it.entry_slot = 8'($urandom_range(0, 17));
    end else
      it.mode = MODE_UNUSED;
    return it;
  endfunction

  // one register setting, one idling mix, a run of random items
  task automatic run_phase(input logic [15:0] dlen, input logic [15:0] hlen,
                           input logic [7:0] hsec, input logic [4:0] dcnt,
                           input logic [4:0] hcnt, input int send_pct,
                           input int stall_pct, input int count);
    in_item_t it;
    int       n;
    apply_settings(dlen, hlen, hsec, dcnt, hcnt);
    // the first random phase starts the long output hold while items keep coming
    if (!long_hold) long_hold <= 1'b1;
    send_idle_pct  = send_pct;
    recv_stall_pct <= stall_pct;
    n = 0;
    while (n < count) begin
      it = make_item();
      if (it.mode != MODE_UNUSED) n++;
      send_item(it);
      if ($urandom_range(99) < 2) wait_results(0);
    end
  endtask

  initial begin
    int          i;
    logic [31:0] probe_times [10];
    probe_times = '{32'd0, 32'd5, 32'd39, 32'd40, 32'd44, 32'd48,
                    32'd59, 32'd60, 32'd12345, 32'hFFFFFFFF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both tables, with extreme entries at the top
    for (i = 0; i < DATA_SLOTS; i++)
      send_item('{MODE_DATA, node_pool[i % 6], 32'd0, 4'(i), 16'(3 * i), 16'd4, 8'(i + 1)});
    send_item('{MODE_DATA, node_pool[2], 32'hFFFFFFFF, 4'd14, 16'd0, 16'hFFFF, 8'hFF});
    send_item('{MODE_DATA, 24'hFFFFFF, 32'd0, 4'd15, 16'hFFFF, 16'hFFFF, 8'h80});
    for (i = 0; i < HELLO_SLOTS; i++)
      send_item('{MODE_HELLO, node_pool[(i + 1) % 6], 32'd0, 4'(i), 16'd0, 16'd0, 8'(i)});
    send_item('{MODE_HELLO, 24'hABCDEF, 32'd0, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF});

    // reset settings: no data entries and no hello slots counted
    send_item('{MODE_QUERY, node_pool[0], 32'd0, 4'd0, 16'd0, 16'd0, 8'd0});
    send_item('{MODE_QUERY, 24'hFFFFFF, 32'hFFFFFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF});
    send_item('{MODE_UNUSED, 24'hFFFFFF, 32'hFFFFFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF});

    // default lengths with both tables counted, across both phases
    apply_settings(16'd40, 16'd20, 8'd4, 5'd16, 5'd5);
    for (i = 0; i < 10; i++)
      send_item('{MODE_QUERY, (i == 9) ? 24'h123456 : node_pool[i % 6], probe_times[i],
                  4'd0, 16'd0, 16'd0, 8'd0});

    // zero lengths: data window off, phases fall back to defaults
    apply_settings(16'd0, 16'd0, 8'd4, 5'd16, 5'd5);
    send_item('{MODE_QUERY, node_pool[1], 32'd40, 4'd0, 16'd0, 16'd0, 8'd0});
    send_item('{MODE_QUERY, node_pool[2], 32'd59, 4'd0, 16'd0, 16'd0, 8'd0});
    send_item('{MODE_QUERY, node_pool[3], 32'd60, 4'd0, 16'd0, 16'd0, 8'd0});

    // random phases; the first holds the output off for a long stretch
    run_phase(16'd40, 16'd20, 8'd4, 5'd16, 5'd5, 0, 0, 50);
    run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 5'd16, 5'd16, 47, 0, 50);
    run_phase(16'd1, 16'd1, 8'd1, 5'd1, 5'd1, 0, 47, 50);
    run_phase(16'd0, 16'd0, 8'd3, 5'd8, 5'd7, 17, 17, 50);
    run_phase(16'd100, 16'd60, 8'd10, 5'd31, 5'd17, 0, 0, 50);
    run_phase(16'd30, 16'd0, 8'd2, 5'd0, 5'd16, 47, 0, 50);
    run_phase(16'($urandom_range(1, 200)), 16'($urandom_range(1, 100)),
              8'($urandom_range(0, 20)), 5'($urandom_range(0, 16)),
              5'($urandom_range(0, 16)), 0, 47, 50);
    run_phase(16'hFFFF, 16'd1, 8'hFF, 5'd16, 5'd16, 17, 17, 50);

    wait_results(SETTLE_CYCLES);
    if (sb.awaited.size() != 0) begin
      $error("%0d results never arrived", sb.awaited.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
